### hdl/ipm_pkg.sv
// ----------------------------------------------------------------------------
// ipm_pkg
// Shared types, widths and constants for the inverse perspective pixel mapper.
// ----------------------------------------------------------------------------
package ipm_pkg;

    localparam int COORD_W = 16;
    localparam int PIX_W   = 8;
    localparam int CFG_W   = 32;
    localparam int INV_W   = 31;
    localparam int IDX_W   = 3;
    localparam int ROW_W   = 9;
    localparam int COL_W   = 9;

    // y * Q16.16 product, numerator / denominator in Q.20 with sign margin
    localparam int PROD_W  = COORD_W + CFG_W;
    localparam int NUM_W   = COORD_W + 34;
    localparam int REM_W   = NUM_W + 3;

    // depth in Q4.16
    localparam int QI_W    = 4;
    localparam int QF_W    = 16;
    localparam int DQ_W    = QI_W + QF_W;
    localparam int DIV_N   = DQ_W;

    localparam int P_W     = DQ_W + 1 + CFG_W;
    localparam int S32_W   = P_W + 1;
    localparam int S16_W   = S32_W - 16;
    localparam int MAG_W   = S16_W;
    localparam int LO_W    = 32;
    localparam int HI_W    = MAG_W - LO_W;
    localparam int LOP_W   = LO_W + INV_W;
    localparam int HIP_W   = HI_W + INV_W;
    localparam int FULL_W  = MAG_W + INV_W + 1;
    localparam int TM_W    = 38;
    localparam int T_W     = TM_W + 1;
    localparam int X_W     = COORD_W + T_W;
    localparam int RV_W    = 28;
    localparam int CV_W    = X_W + 7;

    localparam logic [FULL_W-1:0] T_LIM = FULL_W'(48) << 32;
    localparam logic signed [X_W-1:0] LAT_LIM = X_W'(3) << 36;
    localparam logic signed [RV_W-1:0] ROW_BASE = RV_W'(500) << 16;
    localparam logic signed [RV_W-1:0] ROW_SCALE = RV_W'(50);
    localparam logic signed [CV_W-1:0] COL_BASE = CV_W'(150) << 36;
    localparam logic signed [CV_W-1:0] COL_SCALE = CV_W'(50);
    localparam logic [ROW_W-1:0] ROW_MAX = ROW_W'(449);
    localparam logic [COL_W-1:0] COL_MAX = COL_W'(299);

    typedef enum logic [IDX_W-1:0] {
        REG_H_SIN     = 3'd0,
        REG_COS       = 3'd1,
        REG_F_H_COS   = 3'd2,
        REG_F_SIN     = 3'd3,
        REG_INV_FOCAL = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [CFG_W-1:0] h_sin;
        logic [CFG_W-1:0] cos_p;
        logic [CFG_W-1:0] f_h_cos;
        logic [CFG_W-1:0] f_sin;
        logic [INV_W-1:0] inv_focal;
    } t_cfg;

    // classified item between front and back; den is a non-negative magnitude and num carries the matching sign
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [PIX_W-1:0]   pix;
        logic               pass;
        logic [NUM_W-1:0]   num;
        logic [NUM_W-1:0]   den;
    } t_item;

    typedef struct packed {
        logic               v;
        logic               pass;
        logic [COORD_W-1:0] x;
        logic [PIX_W-1:0]   pix;
        logic [NUM_W-1:0]   den;
        logic [REM_W-1:0]   rem;
        logic [DQ_W-1:0]    q;
    } t_div;

endpackage

### hdl/ipm_front.sv
// ----------------------------------------------------------------------------
// ipm_front
// Accepts pixels, forms the depth numerator and denominator, classifies.
// ----------------------------------------------------------------------------
module ipm_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [ipm_pkg::COORD_W-1:0] i_x,
    input  logic [ipm_pkg::COORD_W-1:0] i_y,
    input  logic [ipm_pkg::PIX_W-1:0]   i_pix,
    input  ipm_pkg::t_cfg               i_cfg,
    input  logic                        i_full,
    output logic                        o_push,
    output ipm_pkg::t_item              o_item
);

    logic                               fe;
    logic                               r_v1, r_v2, r_v3;
    logic [ipm_pkg::COORD_W-1:0]        r_x1, r_x2;
    logic [ipm_pkg::PIX_W-1:0]          r_pix1, r_pix2;
    logic signed [ipm_pkg::PROD_W-1:0]  r_yh, r_yc;
    logic signed [ipm_pkg::NUM_W-1:0]   r_num, r_den;
    logic signed [ipm_pkg::NUM_W-1:0]   num, den, num_n, den_n;
    logic signed [ipm_pkg::NUM_W+3:0]   den10;
    ipm_pkg::t_item                     r_item, n_item;

    assign fe      = !(r_v3 && i_full);
    assign o_ready = fe;
    assign o_push  = r_v3 && !i_full;
    assign o_item  = r_item;

    always_comb begin
        num   = r_yh + ($signed(i_cfg.f_h_cos) <<< 4);
        den   = ($signed(i_cfg.f_sin) <<< 4) - r_yc;
        num_n = (den < 0) ? -num : num;
        den_n = (den < 0) ? -den : den;
    end

    always_comb begin
        den10       = (r_den <<< 3) + (r_den <<< 1);
        n_item.x    = r_x2;
        n_item.pix  = r_pix2;
        n_item.pass = (r_den != 0) && (r_num > r_den) && (r_num < den10);
        n_item.num  = r_num[ipm_pkg::NUM_W-1:0];
        n_item.den  = r_den[ipm_pkg::NUM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (fe) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fe) begin
            r_x1   <= i_x;
            r_pix1 <= i_pix;
            r_yh   <= $signed(i_y) * $signed(i_cfg.h_sin);
            r_yc   <= $signed(i_y) * $signed(i_cfg.cos_p);
            r_x2   <= r_x1;
            r_pix2 <= r_pix1;
            r_num  <= num_n;
            r_den  <= den_n;
            r_item <= n_item;
        end
    end

endmodule

### hdl/ipm_queue.sv
// ----------------------------------------------------------------------------
// ipm_queue
// Four-entry queue decoupling the classifier from the mapping pipeline.
// ----------------------------------------------------------------------------
module ipm_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ipm_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output ipm_pkg::t_item o_item
);

    ipm_pkg::t_item r_mem [0:3];
    logic [1:0]     r_wp, r_rp;
    logic [2:0]     r_cnt;

    assign o_full  = (r_cnt == 3'd4);
    assign o_empty = (r_cnt == 3'd0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 2'd0;
            r_rp  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            if (i_push) r_wp <= r_wp + 2'd1;
            if (i_pop)  r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + 3'(i_push) - 3'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_item;
    end

endmodule

### hdl/ipm_back.sv
// ----------------------------------------------------------------------------
// ipm_back
// Pipelined depth division, lateral offset and map coordinate stages.
// ----------------------------------------------------------------------------
module ipm_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  ipm_pkg::t_cfg             i_cfg,
    input  logic                      i_empty,
    input  ipm_pkg::t_item            i_item,
    output logic                      o_pop,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic                      o_hit,
    output logic [ipm_pkg::ROW_W-1:0] o_row,
    output logic [ipm_pkg::COL_W-1:0] o_col,
    output logic [ipm_pkg::PIX_W-1:0] o_pix
);

    logic           be;
    ipm_pkg::t_div  r_div [0:ipm_pkg::DIV_N];
    ipm_pkg::t_div  n_div [1:ipm_pkg::DIV_N];

    // stage A..E payload
    logic                               r_va, r_vb, r_vc, r_vd, r_ve;
    logic                               r_pa, r_pb, r_pc, r_pd, r_pe;
    logic [ipm_pkg::COORD_W-1:0]        r_xa, r_xb, r_xc, r_xd, r_xe;
    logic [ipm_pkg::PIX_W-1:0]          r_pxa, r_pxb, r_pxc, r_pxd, r_pxe;
    logic [ipm_pkg::DQ_W-1:0]           r_dqa, r_dqb, r_dqc, r_dqd, r_dqe;
    logic signed [ipm_pkg::P_W-1:0]     r_p;
    logic                               r_negb, r_negc;
    logic [ipm_pkg::MAG_W-1:0]          r_mag;
    logic [ipm_pkg::LOP_W-1:0]          r_lo;
    logic [ipm_pkg::HIP_W-1:0]          r_hi;
    logic signed [ipm_pkg::T_W-1:0]     r_t;
    logic signed [ipm_pkg::X_W-1:0]     r_x36;

    logic signed [ipm_pkg::S32_W-1:0]   s32;
    logic signed [ipm_pkg::S16_W-1:0]   s16;
    logic [ipm_pkg::MAG_W-1:0]          mag;
    logic [ipm_pkg::FULL_W-1:0]         full;
    logic [ipm_pkg::TM_W-1:0]           tm;
    logic signed [ipm_pkg::T_W-1:0]     t;
    logic signed [ipm_pkg::RV_W-1:0]    rowv;
    logic signed [ipm_pkg::CV_W-1:0]    colv;
    logic [ipm_pkg::RV_W-17:0]          row_w;
    logic [ipm_pkg::CV_W-37:0]          col_w;
    logic                               hit;
    logic [ipm_pkg::ROW_W-1:0]          row;
    logic [ipm_pkg::COL_W-1:0]          col;

    logic                               r_ov, r_hit;
    logic [ipm_pkg::ROW_W-1:0]          r_row;
    logic [ipm_pkg::COL_W-1:0]          r_col;
    logic [ipm_pkg::PIX_W-1:0]          r_pix;

    assign be      = !r_ov || i_ready;
    assign o_pop   = be && !i_empty;
    assign o_valid = r_ov;
    assign o_hit   = r_hit;
    assign o_row   = r_row;
    assign o_col   = r_col;
    assign o_pix   = r_pix;

    // restoring division: four integer quotient bits, then sixteen fraction bits
    for (genvar g = 0; g < ipm_pkg::DIV_N; g++) begin : g_div
        logic [ipm_pkg::REM_W-1:0] rem_s, trial;
        logic                      ge;
        always_comb begin
            if (g < ipm_pkg::QI_W) begin
                rem_s = r_div[g].rem;
                trial = ipm_pkg::REM_W'(r_div[g].den) << (ipm_pkg::QI_W - 1 - g);
            end else begin
                rem_s = r_div[g].rem << 1;
                trial = ipm_pkg::REM_W'(r_div[g].den);
            end
            ge             = (rem_s >= trial);
            n_div[g+1]     = r_div[g];
            n_div[g+1].rem = ge ? (rem_s - trial) : rem_s;
            n_div[g+1].q   = {r_div[g].q[ipm_pkg::DQ_W-2:0], ge};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_div[g+1].v <= 1'b0;
            end else if (be) begin
                r_div[g+1].v <= n_div[g+1].v;
            end
        end
        always_ff @(posedge i_clk) begin
            if (be) begin
                r_div[g+1].pass <= n_div[g+1].pass;
                r_div[g+1].x    <= n_div[g+1].x;
                r_div[g+1].pix  <= n_div[g+1].pix;
                r_div[g+1].den  <= n_div[g+1].den;
                r_div[g+1].rem  <= n_div[g+1].rem;
                r_div[g+1].q    <= n_div[g+1].q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div[0].v <= 1'b0;
        end else if (be) begin
            r_div[0].v <= !i_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (be) begin
            r_div[0].pass <= i_item.pass;
            r_div[0].x    <= i_item.x;
            r_div[0].pix  <= i_item.pix;
            r_div[0].den  <= i_item.den;
            r_div[0].rem  <= ipm_pkg::REM_W'(i_item.num);
            r_div[0].q    <= '0;
        end
    end

    // S = h_sin + D*cos, floored to Q.16, then T = |S| * inv_focal saturated
    always_comb begin
        s32  = ($signed(i_cfg.h_sin) <<< 16) + r_p;
        s16  = ipm_pkg::S16_W'(s32 >>> 16);
        mag  = (s16 < 0) ? ipm_pkg::MAG_W'(-s16) : ipm_pkg::MAG_W'(s16);
        full = ipm_pkg::FULL_W'(r_lo) + (ipm_pkg::FULL_W'(r_hi) << 32);
        tm   = (full > ipm_pkg::T_LIM) ? ipm_pkg::T_LIM[ipm_pkg::TM_W-1:0]
                                       : full[ipm_pkg::TM_W-1:0];
        t    = r_negc ? -$signed({1'b0, tm}) : $signed({1'b0, tm});
    end

    // hit test and map coordinates
    always_comb begin
        hit   = r_pe && (r_x36 < ipm_pkg::LAT_LIM) && (r_x36 > -ipm_pkg::LAT_LIM);
        rowv  = ipm_pkg::ROW_BASE - ipm_pkg::ROW_SCALE * $signed({1'b0, r_dqe});
        colv  = ipm_pkg::COL_BASE - ipm_pkg::COL_SCALE * r_x36;
        row_w = (rowv < 0) ? '0 : rowv[ipm_pkg::RV_W-1:16];
        col_w = (colv < 0) ? '0 : colv[ipm_pkg::CV_W-1:36];
        row   = (row_w > (ipm_pkg::RV_W-16)'(ipm_pkg::ROW_MAX)) ? ipm_pkg::ROW_MAX
                                                             : row_w[ipm_pkg::ROW_W-1:0];
        col   = (col_w > (ipm_pkg::CV_W-36)'(ipm_pkg::COL_MAX)) ? ipm_pkg::COL_MAX
                                                             : col_w[ipm_pkg::COL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
            r_ve <= 1'b0;
            r_ov <= 1'b0;
        end else if (be) begin
            r_va <= r_div[ipm_pkg::DIV_N].v;
            r_vb <= r_va;
            r_vc <= r_vb;
            r_vd <= r_vc;
            r_ve <= r_vd;
            r_ov <= r_ve;
        end
    end

    always_ff @(posedge i_clk) begin
        if (be) begin
            r_pa   <= r_div[ipm_pkg::DIV_N].pass;
            r_xa   <= r_div[ipm_pkg::DIV_N].x;
            r_pxa  <= r_div[ipm_pkg::DIV_N].pix;
            r_dqa  <= r_div[ipm_pkg::DIV_N].q;
            r_p    <= $signed({1'b0, r_div[ipm_pkg::DIV_N].q}) * $signed(i_cfg.cos_p);

            r_pb   <= r_pa;
            r_xb   <= r_xa;
            r_pxb  <= r_pxa;
            r_dqb  <= r_dqa;
            r_negb <= (s16 < 0);
            r_mag  <= mag;

            r_pc   <= r_pb;
            r_xc   <= r_xb;
            r_pxc  <= r_pxb;
            r_dqc  <= r_dqb;
            r_negc <= r_negb;
            r_lo   <= r_mag[ipm_pkg::LO_W-1:0] * i_cfg.inv_focal;
            r_hi   <= r_mag[ipm_pkg::MAG_W-1:ipm_pkg::LO_W] * i_cfg.inv_focal;

            r_pd   <= r_pc;
            r_xd   <= r_xc;
            r_pxd  <= r_pxc;
            r_dqd  <= r_dqc;
            r_t    <= t;

            r_pe   <= r_pd;
            r_xe   <= r_xd;
            r_pxe  <= r_pxd;
            r_dqe  <= r_dqd;
            r_x36  <= $signed(r_xd) * r_t;

            r_hit  <= hit;
            r_row  <= hit ? row : '0;
            r_col  <= hit ? col : '0;
            r_pix  <= hit ? r_pxe : '0;
        end
    end

endmodule

### hdl/inverse_perspective_pixel_map.sv
// ----------------------------------------------------------------------------
// inverse_perspective_pixel_map
// Maps camera-plane pixels onto a 450 x 300 bird's-eye road map.
// ----------------------------------------------------------------------------
// One pixel is accepted every clock; the block stalls only when the result
// side holds off. With the queue empty, a pixel passes through three classify
// stages, one queue slot, the divider entry register and twenty divider
// stages (one quotient bit each), then six mapping stages up to the output
// register. Configuration writes take effect at once and must be made while
// no pixel is in flight.
// ----------------------------------------------------------------------------
module inverse_perspective_pixel_map (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [39:0]               s_axis_tdata,   // cam_x, cam_y, pixel_value
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [31:0]               m_axis_tdata,   // map_row, map_col, out_value
    output logic                      m_axis_tuser,   // hit
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [ipm_pkg::IDX_W-1:0] i_cfg_index,
    input  logic [ipm_pkg::CFG_W-1:0] i_cfg_data
);

    ipm_pkg::t_cfg             r_cfg;
    ipm_pkg::t_item            f_item, q_item;
    logic                      q_push, q_full;
    logic                      q_empty, q_pop;
    logic [ipm_pkg::ROW_W-1:0] row;
    logic [ipm_pkg::COL_W-1:0] col;
    logic [ipm_pkg::PIX_W-1:0] pix;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.h_sin     <= '0;
            r_cfg.cos_p     <= ipm_pkg::CFG_W'(65536);
            r_cfg.f_h_cos   <= '0;
            r_cfg.f_sin     <= '0;
            r_cfg.inv_focal <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ipm_pkg::REG_H_SIN:     r_cfg.h_sin     <= i_cfg_data;
                ipm_pkg::REG_COS:       r_cfg.cos_p     <= i_cfg_data;
                ipm_pkg::REG_F_H_COS:   r_cfg.f_h_cos   <= i_cfg_data;
                ipm_pkg::REG_F_SIN:     r_cfg.f_sin     <= i_cfg_data;
                ipm_pkg::REG_INV_FOCAL: r_cfg.inv_focal <= i_cfg_data[ipm_pkg::INV_W-1:0];
                default: ;
            endcase
        end
    end

    ipm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_x     (s_axis_tdata[15:0]),
        .i_y     (s_axis_tdata[31:16]),
        .i_pix   (s_axis_tdata[39:32]),
        .i_cfg   (r_cfg),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_item  (f_item)
    );

    ipm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (f_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_item  (q_item)
    );

    ipm_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_empty (q_empty),
        .i_item  (q_item),
        .o_pop   (q_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_hit   (m_axis_tuser),
        .o_row   (row),
        .o_col   (col),
        .o_pix   (pix)
    );

    assign m_axis_tdata = {6'd0, pix, col, row};

endmodule
